@@ design/tnlm_pkg.sv @@
package tnlm_pkg;

    localparam int ElemW     = 16;
    localparam int FieldW    = 16;
    localparam int LblW      = 16;
    localparam int MaxRows   = 1024;
    localparam int IdxW      = $clog2(MaxRows);
    localparam int DistW     = 48;
    localparam int SqW       = 2 * ElemW;
    localparam int NumSlots  = 3;
    localparam int CntW      = 2;
    localparam int InDataW   = 4 * FieldW;
    localparam int ResW      = 1 + 3 * IdxW + DistW + CntW;
    localparam int OutDataW  = ((ResW + 7) / 8) * 8;

    localparam logic [DistW-1:0] DistEmpty = '1;

    typedef struct packed {
        logic [FieldW-1:0] train_value;
        logic [FieldW-1:0] query_value;
        logic [LblW-1:0]   train_label;
        logic [LblW-1:0]   query_label;
        logic              row_end;
        logic              query_end;
    } in_item_t;

    typedef struct packed {
        logic [SqW-1:0]  sq;
        logic [LblW-1:0] train_label;
        logic [LblW-1:0] query_label;
        logic            row_end;
        logic            query_end;
    } sq_item_t;

    typedef struct packed {
        logic [DistW-1:0] distance;
        logic [IdxW-1:0]  idx;
        logic [LblW-1:0]  label;
        logic [LblW-1:0]  query_label;
        logic             query_end;
    } row_item_t;

    typedef struct packed {
        logic             label_hit;
        logic [IdxW-1:0]  first_index;
        logic [IdxW-1:0]  second_index;
        logic [IdxW-1:0]  third_index;
        logic [DistW-1:0] best_distance;
        logic [CntW-1:0]  slots_filled;
    } result_t;

endpackage

@@ design/tnlm_sqdiff.sv @@
module tnlm_sqdiff (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                in_valid,
    input  tnlm_pkg::in_item_t  in_item,
    output logic                sq_valid,
    output tnlm_pkg::sq_item_t  sq_item
);

    logic                             in_valid_reg;
    tnlm_pkg::in_item_t               in_reg;
    logic                             sq_valid_reg;
    tnlm_pkg::sq_item_t               sq_reg;
    tnlm_pkg::sq_item_t               sq_next;

    logic [tnlm_pkg::ElemW-1:0]       t_val;
    logic [tnlm_pkg::ElemW-1:0]       q_val;
    logic [tnlm_pkg::ElemW:0]         diff;
    logic [tnlm_pkg::ElemW:0]         diff_neg;
    logic [tnlm_pkg::ElemW-1:0]       mag;

    always_comb begin
        t_val    = in_reg.train_value[tnlm_pkg::ElemW-1:0];
        q_val    = in_reg.query_value[tnlm_pkg::ElemW-1:0];
        diff     = {t_val[tnlm_pkg::ElemW-1], t_val} - {q_val[tnlm_pkg::ElemW-1], q_val};
        diff_neg = -diff;
        mag      = diff[tnlm_pkg::ElemW] ? diff_neg[tnlm_pkg::ElemW-1:0]
                                         : diff[tnlm_pkg::ElemW-1:0];
        sq_next.sq          = tnlm_pkg::SqW'(mag) * tnlm_pkg::SqW'(mag);
        sq_next.train_label = in_reg.train_label;
        sq_next.query_label = in_reg.query_label;
        sq_next.row_end     = in_reg.row_end;
        sq_next.query_end   = in_reg.query_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= in_valid;
            sq_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            in_reg <= in_item;
            sq_reg <= sq_next;
        end
    end

    assign sq_valid = sq_valid_reg;
    assign sq_item  = sq_reg;

endmodule

@@ design/tnlm_acc.sv @@
module tnlm_acc (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                sq_valid,
    input  tnlm_pkg::sq_item_t  sq_item,
    output logic                row_valid,
    output tnlm_pkg::row_item_t row_item
);

    logic [tnlm_pkg::DistW-1:0] acc_reg;
    logic [tnlm_pkg::DistW-1:0] acc_next;
    logic [tnlm_pkg::IdxW-1:0]  row_cnt_reg;
    logic [tnlm_pkg::IdxW-1:0]  row_cnt_next;
    logic                       row_valid_reg;
    tnlm_pkg::row_item_t        row_reg;
    tnlm_pkg::row_item_t        row_next;

    logic [tnlm_pkg::DistW:0]   sum;
    logic [tnlm_pkg::DistW-1:0] sat;
    logic                       closes;

    always_comb begin
        sum    = {1'b0, acc_reg} + (tnlm_pkg::DistW + 1)'(sq_item.sq);
        sat    = sum[tnlm_pkg::DistW] ? tnlm_pkg::DistEmpty : sum[tnlm_pkg::DistW-1:0];
        closes = sq_valid && (sq_item.row_end || sq_item.query_end);

        acc_next     = acc_reg;
        row_cnt_next = row_cnt_reg;
        if (closes) begin
            acc_next = '0;
            if (sq_item.query_end || row_cnt_reg == tnlm_pkg::IdxW'(tnlm_pkg::MaxRows - 1)) begin
                row_cnt_next = '0;
            end else begin
                row_cnt_next = row_cnt_reg + tnlm_pkg::IdxW'(1);
            end
        end else if (sq_valid) begin
            acc_next = sat;
        end

        row_next.distance    = sat;
        row_next.idx         = row_cnt_reg;
        row_next.label       = sq_item.train_label;
        row_next.query_label = sq_item.query_label;
        row_next.query_end   = sq_item.query_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            row_cnt_reg   <= '0;
            row_valid_reg <= 1'b0;
        end else if (advance) begin
            acc_reg       <= acc_next;
            row_cnt_reg   <= row_cnt_next;
            row_valid_reg <= closes;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            row_reg <= row_next;
        end
    end

    assign row_valid = row_valid_reg;
    assign row_item  = row_reg;

endmodule

@@ design/tnlm_slots.sv @@
module tnlm_slots (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                row_valid,
    input  tnlm_pkg::row_item_t row_item,
    input  logic                res_ready,
    output logic                advance,
    output logic                res_valid,
    output tnlm_pkg::result_t   res
);

    logic [tnlm_pkg::DistW-1:0] dist_reg [tnlm_pkg::NumSlots];
    logic [tnlm_pkg::IdxW-1:0]  idx_reg  [tnlm_pkg::NumSlots];
    logic [tnlm_pkg::LblW-1:0]  lbl_reg  [tnlm_pkg::NumSlots];
    logic [tnlm_pkg::CntW-1:0]  cnt_reg;

    logic [tnlm_pkg::DistW-1:0] dist_next [tnlm_pkg::NumSlots];
    logic [tnlm_pkg::IdxW-1:0]  idx_next  [tnlm_pkg::NumSlots];
    logic [tnlm_pkg::LblW-1:0]  lbl_next  [tnlm_pkg::NumSlots];
    logic [tnlm_pkg::CntW-1:0]  cnt_next;

    logic [tnlm_pkg::NumSlots-1:0] le;
    logic [tnlm_pkg::NumSlots-1:0] ahead;
    logic                          res_valid_reg;
    tnlm_pkg::result_t             res_reg;
    tnlm_pkg::result_t             res_next;
    logic                          hit;

    // stall only when a query result meets a full output register
    assign advance = !(row_valid && row_item.query_end && res_valid_reg && !res_ready);

    always_comb begin
        for (int k = 0; k < tnlm_pkg::NumSlots; k++) begin
            le[k] = (tnlm_pkg::CntW'(k) < cnt_reg) && (dist_reg[k] <= row_item.distance);
        end
        ahead[0] = 1'b1;
        for (int k = 1; k < tnlm_pkg::NumSlots; k++) begin
            ahead[k] = ahead[k-1] && le[k-1];
        end

        for (int k = 0; k < tnlm_pkg::NumSlots; k++) begin
            dist_next[k] = dist_reg[k];
            idx_next[k]  = idx_reg[k];
            lbl_next[k]  = lbl_reg[k];
            if (row_valid) begin
                if (ahead[k] && !le[k]) begin
                    dist_next[k] = row_item.distance;
                    idx_next[k]  = row_item.idx;
                    lbl_next[k]  = row_item.label;
                end else if (!ahead[k] && k > 0) begin
                    dist_next[k] = dist_reg[k-1];
                    idx_next[k]  = idx_reg[k-1];
                    lbl_next[k]  = lbl_reg[k-1];
                end
            end
        end

        cnt_next = cnt_reg;
        if (row_valid && !(&le) && cnt_reg != tnlm_pkg::CntW'(tnlm_pkg::NumSlots)) begin
            cnt_next = cnt_reg + tnlm_pkg::CntW'(1);
        end

        hit = 1'b0;
        for (int k = 0; k < tnlm_pkg::NumSlots; k++) begin
            if (tnlm_pkg::CntW'(k) < cnt_next && lbl_next[k] == row_item.query_label) begin
                hit = 1'b1;
            end
        end

        res_next.label_hit     = hit;
        res_next.first_index   = (cnt_next > 2'd0) ? idx_next[0] : '0;
        res_next.second_index  = (cnt_next > 2'd1) ? idx_next[1] : '0;
        res_next.third_index   = (cnt_next > 2'd2) ? idx_next[2] : '0;
        res_next.best_distance = (cnt_next > 2'd0) ? dist_next[0] : '0;
        res_next.slots_filled  = cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < tnlm_pkg::NumSlots; k++) begin
                dist_reg[k] <= tnlm_pkg::DistEmpty;
                idx_reg[k]  <= '0;
                lbl_reg[k]  <= '0;
            end
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (advance && row_valid) begin
                if (row_item.query_end) begin
                    for (int k = 0; k < tnlm_pkg::NumSlots; k++) begin
                        dist_reg[k] <= tnlm_pkg::DistEmpty;
                        idx_reg[k]  <= '0;
                        lbl_reg[k]  <= '0;
                    end
                    cnt_reg <= '0;
                end else begin
                    for (int k = 0; k < tnlm_pkg::NumSlots; k++) begin
                        dist_reg[k] <= dist_next[k];
                        idx_reg[k]  <= idx_next[k];
                        lbl_reg[k]  <= lbl_next[k];
                    end
                    cnt_reg <= cnt_next;
                end
            end
            if (advance && row_valid && row_item.query_end) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && row_valid && row_item.query_end) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ design/three_nearest_label_match_top.sv @@
// Channel | Direction | Ports                     | Request
// s_      | in        | tvalid tready tdata tlast | one training/query element pair
//         |           | tuser                     |
// m_      | out       | tvalid tready tdata       | one query report
//
// One request per cycle while s_tready is high; a report leaves once its query-end request has passed every stage.
// Depth is set by the register stages: input, square, row accumulate, slot insert.
// Synchronous active-low reset clears the accumulator, row count and all slots.
// Input stalls only when a query report reaches a still-full output register.
module three_nearest_label_match_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // train_value[15:0], query_value[31:16], train_label[47:32], query_label[63:48]
    input  logic [tnlm_pkg::InDataW-1:0]  s_tdata,
    input  logic                          s_tlast,  // query_end
    input  logic                          s_tuser,  // row_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // label_hit[0], first_index[10:1], second_index[20:11], third_index[30:21],
    // best_distance[78:31], slots_filled[80:79], zero fill [87:81]
    output logic [tnlm_pkg::OutDataW-1:0] m_tdata
);

    tnlm_pkg::in_item_t  in_item;
    logic                advance;
    logic                sq_valid;
    tnlm_pkg::sq_item_t  sq_item;
    logic                row_valid;
    tnlm_pkg::row_item_t row_item;
    tnlm_pkg::result_t   res;

    always_comb begin
        in_item.train_value = s_tdata[tnlm_pkg::FieldW-1:0];
        in_item.query_value = s_tdata[2*tnlm_pkg::FieldW-1:tnlm_pkg::FieldW];
        in_item.train_label = s_tdata[3*tnlm_pkg::FieldW-1:2*tnlm_pkg::FieldW];
        in_item.query_label = s_tdata[4*tnlm_pkg::FieldW-1:3*tnlm_pkg::FieldW];
        in_item.row_end     = s_tuser;
        in_item.query_end   = s_tlast;
    end

    assign s_tready = advance;

    tnlm_sqdiff u_sqdiff (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_valid (s_tvalid),
        .in_item  (in_item),
        .sq_valid (sq_valid),
        .sq_item  (sq_item)
    );

    tnlm_acc u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .sq_valid  (sq_valid),
        .sq_item   (sq_item),
        .row_valid (row_valid),
        .row_item  (row_item)
    );

    tnlm_slots u_slots (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .row_valid (row_valid),
        .row_item  (row_item),
        .res_ready (m_tready),
        .advance   (advance),
        .res_valid (m_tvalid),
        .res       (res)
    );

    assign m_tdata = {{(tnlm_pkg::OutDataW - tnlm_pkg::ResW){1'b0}},
                      res.slots_filled,
                      res.best_distance,
                      res.third_index,
                      res.second_index,
                      res.first_index,
                      res.label_hit};

endmodule
